// ===== design/sddp_pkg.sv =====
// Shared types and constants for the scale disk dilation painter.
// Used by sddp_engine and scale_disk_dilation_painter; no dependencies.
`default_nettype none

package sddp_pkg;

  // Image and scale limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int SCALE_CAP  = 31;

  // Field widths
  localparam int OP_W    = 2;
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int SCALE_W = 5;
  localparam int DIM_W   = 9;
  localparam int COEF_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Offset window: |d| <= scale + 1
  localparam int SPAN_MAX = SCALE_CAP + 1;
  localparam int MAG_W    = $clog2(SPAN_MAX + 1);
  localparam int OFS_W    = MAG_W + 1;
  localparam int POS_W    = ((ROW_W > COL_W) ? ROW_W : COL_W) + 2;

  // Shared multiplier and distance test
  localparam int MUL_W     = 16;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int RY_W      = MAG_W + COEF_W;
  localparam int SQ_IN_W   = 15;          // products at or above 2^15 always miss
  localparam int SQ_W      = 2 * SQ_IN_W;
  localparam int SUM_W     = SQ_W + 1;
  localparam int ROOT_W    = $clog2(2 * SCALE_CAP);
  localparam int LIM_W     = 2 * ROOT_W;
  localparam int THR_SHIFT = 14;          // (2s-1)^2 * 2^16 / 4

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COEF     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COEF     = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PAINT = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LIM,
    ST_ROW,
    ST_RSQ,
    ST_CX,
    ST_CSQ,
    ST_CMP,
    ST_WRITE,
    ST_RD_WAIT,
    ST_RD_OUT
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [SCALE_W-1:0] scale;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0]  eff_w;
    logic [DIM_W-1:0]  eff_h;
    logic [COEF_W-1:0] row_coef;
    logic [COEF_W-1:0] col_coef;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
    logic res_bit;
  } status_t;

endpackage

`default_nettype wire

// ===== design/sddp_engine.sv =====
// Mask store, shared multiplier and operation sequencer of the painter.
// Depends on sddp_pkg.
`default_nettype none

module sddp_engine
  import sddp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cmd_valid,
  input  wire cmd_t    cmd,
  input  wire cfg_t    cfg,
  input  wire logic    res_ready,
  output status_t      status
);

  // Mask memory: one row per entry
  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rd_data;
  logic                 rd_en;
  logic [ROW_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [ROW_W-1:0]     wr_addr;
  logic [MAX_WIDTH-1:0] wr_data;

  state_t state, state_next;

  logic [ROW_W-1:0]        clr_addr;
  logic [ROW_W-1:0]        row_r;
  logic [COL_W-1:0]        col_r;
  logic [SCALE_W-1:0]      sc;
  logic [MAG_W-1:0]        span;
  logic signed [OFS_W-1:0] dy;
  logic signed [OFS_W-1:0] dx;
  logic [ROW_W-1:0]        y_r;
  logic [COL_W-1:0]        x_r;
  logic [LIM_W-1:0]        lim_sq;
  logic [RY_W-1:0]         ry;
  logic [SQ_W-1:0]         ry2;
  logic [RY_W-1:0]         cx;
  logic [SQ_W-1:0]         cx2;
  logic [MAX_WIDTH-1:0]    rowbuf;
  logic                    res_bit;

  logic [SCALE_W-1:0]      s_eff;
  logic [MAG_W-1:0]        span_in;
  logic                    rd_in;
  logic signed [POS_W-1:0] y_pos;
  logic signed [POS_W-1:0] x_pos;
  logic                    y_in;
  logic                    x_in;
  logic                    last_dy;
  logic                    last_dx;
  logic [MAG_W-1:0]        dy_mag;
  logic [MAG_W-1:0]        dx_mag;
  logic [SQ_IN_W-1:0]      ry_sat;
  logic [SQ_IN_W-1:0]      cx_sat;
  logic [SCALE_W:0]        root;
  logic                    hit;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic [PROD_W-1:0]       mul_p;

  // Command decode
  assign s_eff   = (cmd.scale > SCALE_W'(SCALE_CAP)) ? SCALE_W'(SCALE_CAP) : cmd.scale;
  assign span_in = MAG_W'(s_eff) + MAG_W'(1);
  assign rd_in   = (DIM_W'(cmd.row) < cfg.eff_h) && (DIM_W'(cmd.col) < cfg.eff_w);

  // Current offset position and window
  assign y_pos   = $signed(POS_W'(row_r)) + POS_W'(dy);
  assign x_pos   = $signed(POS_W'(col_r)) + POS_W'(dx);
  assign y_in    = (y_pos >= 0) && (y_pos < $signed(POS_W'(cfg.eff_h)));
  assign x_in    = (x_pos >= 0) && (x_pos < $signed(POS_W'(cfg.eff_w)));
  assign last_dy = (dy == OFS_W'(span));
  assign last_dx = (dx == OFS_W'(span));
  assign dy_mag  = dy[OFS_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  assign dx_mag  = dx[OFS_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
  assign ry_sat  = ((ry >> SQ_IN_W) != '0) ? '1 : ry[SQ_IN_W-1:0];
  assign cx_sat  = ((cx >> SQ_IN_W) != '0) ? '1 : cx[SQ_IN_W-1:0];
  assign root    = {sc, 1'b0} - (SCALE_W+1)'(1);

  // Distance test against the squared limit
  assign hit = (SUM_W'(ry2) + SUM_W'(cx2)) <= (SUM_W'(lim_sq) << THR_SHIFT);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_LIM: begin
        mul_a = MUL_W'(root);
        mul_b = MUL_W'(root);
      end
      ST_ROW: begin
        mul_a = MUL_W'(dy_mag);
        mul_b = cfg.row_coef;
      end
      ST_RSQ: begin
        mul_a = MUL_W'(ry_sat);
        mul_b = MUL_W'(ry_sat);
      end
      ST_CX: begin
        mul_a = MUL_W'(dx_mag);
        mul_b = cfg.col_coef;
      end
      ST_CSQ: begin
        mul_a = MUL_W'(cx_sat);
        mul_b = MUL_W'(cx_sat);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ROW_W'(MAX_HEIGHT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          case (op_t'(cmd.op))
            OP_CLEAR: state_next = ST_CLEAR;
            OP_PAINT: state_next = (s_eff != '0) ? ST_LIM : ST_IDLE;
            OP_READ:  state_next = rd_in ? ST_RD_WAIT : ST_RD_OUT;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_LIM: state_next = ST_ROW;
      ST_ROW: begin
        if (y_in) state_next = ST_RSQ;
        else if (last_dy) state_next = ST_IDLE;
      end
      ST_RSQ: state_next = ST_CX;
      ST_CX: begin
        if (x_in) state_next = ST_CSQ;
        else if (last_dx) state_next = ST_WRITE;
      end
      ST_CSQ: state_next = ST_CMP;
      ST_CMP: state_next = last_dx ? ST_WRITE : ST_CX;
      ST_WRITE: state_next = last_dy ? ST_IDLE : ST_ROW;
      ST_RD_WAIT: state_next = ST_RD_OUT;
      ST_RD_OUT: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      ST_IDLE: begin
        rd_en   = cmd_valid && (op_t'(cmd.op) == OP_READ) && rd_in;
        rd_addr = cmd.row;
      end
      ST_ROW: begin
        rd_en   = y_in;
        rd_addr = y_pos[ROW_W-1:0];
      end
      ST_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = y_r;
        wr_data = rowbuf;
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  // Mask memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + ROW_W'(1);
      else if (state == ST_IDLE) clr_addr <= '0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        row_r   <= cmd.row;
        col_r   <= cmd.col;
        sc      <= s_eff;
        span    <= span_in;
        dy      <= -OFS_W'(span_in);
        res_bit <= 1'b0;
      end
      ST_LIM: lim_sq <= mul_p[LIM_W-1:0];
      ST_ROW: begin
        ry  <= mul_p[RY_W-1:0];
        y_r <= y_pos[ROW_W-1:0];
        if (!y_in) dy <= dy + OFS_W'(1);
      end
      ST_RSQ: begin
        ry2    <= mul_p[SQ_W-1:0];
        rowbuf <= rd_data;
        dx     <= -OFS_W'(span);
      end
      ST_CX: begin
        cx  <= mul_p[RY_W-1:0];
        x_r <= x_pos[COL_W-1:0];
        if (!x_in) dx <= dx + OFS_W'(1);
      end
      ST_CSQ: cx2 <= mul_p[SQ_W-1:0];
      ST_CMP: begin
        if (hit) rowbuf[x_r] <= 1'b1;
        dx <= dx + OFS_W'(1);
      end
      ST_WRITE: dy <= dy + OFS_W'(1);
      ST_RD_WAIT: res_bit <= rd_data[col_r];
      default: begin
      end
    endcase
  end

  assign status.idle      = (state == ST_IDLE);
  assign status.res_valid = (state == ST_RD_OUT);
  assign status.res_bit   = res_bit;

endmodule

`default_nettype wire

// ===== design/scale_disk_dilation_painter.sv =====
// Top level of the scale disk dilation painter: stream ports, config registers
// and output register around sddp_engine. Depends on sddp_pkg, sddp_engine.
//
// Usage:
//   Items enter on s_axis_*: tuser carries the operation (clear, paint, read),
//   tdata carries row, column and scale. Only a read produces an item on
//   m_axis_*, whose tdata bit 0 is the mask bit (0 outside the image in use).
//   Users write registers on the cfg_* channel (always ready) only while idle; not enforced.
// Sequencing (s_axis_tready is low while an item is worked on):
//   clear: the sweep writes one mask row per cycle through the row memory.
//   read: RD_WAIT then RD_OUT in range, only RD_OUT outside the image, then
//   the result register. paint: LIM, then per row of the (2s+3)-row window
//   ROW alone if clipped, else ROW, RSQ, per column CX (and CSQ, CMP if in
//   image), then WRITE. The single shared 16x16 multiplier computes the row
//   term, the column term and both squares in turn.
// Reset: synchronous; registers go to 256/256/1.0/1.0 and the mask is swept
//   to zero, all 256 rows, before s_axis_tready first rises.
// Stall: a read result waits in the output register; new items are still
//   accepted, and a following read holds in the engine until the slot frees.
`default_nettype none

module scale_disk_dilation_painter
  import sddp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input items
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [23:0]           s_axis_tdata,   // pixel_row[7:0], pixel_col[15:8], scale[20:16]
  input  wire logic [OP_W-1:0]       s_axis_tuser,   // operation[1:0]
  // result items
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // mask_bit[0]
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [COEF_W-1:0] row_coef;
  logic [COEF_W-1:0] col_coef;

  cmd_t    cmd;
  cfg_t    cfg;
  status_t status;
  logic    res_ready;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(256);
      image_height <= DIM_W'(256);
      row_coef     <= COEF_W'(256);
      col_coef     <= COEF_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        CFG_ROW_COEF:     row_coef     <= cfg_data[COEF_W-1:0];
        CFG_COL_COEF:     col_coef     <= cfg_data[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective image size, saturated to the store size
  assign cfg.eff_w = (image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : image_width;
  assign cfg.eff_h = (image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : image_height;
  assign cfg.row_coef = row_coef;
  assign cfg.col_coef = col_coef;

  // Input unpack
  assign cmd.op    = s_axis_tuser;
  assign cmd.row   = s_axis_tdata[7:0];
  assign cmd.col   = s_axis_tdata[15:8];
  assign cmd.scale = s_axis_tdata[20:16];

  assign s_axis_tready = status.idle;

  sddp_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_axis_tvalid && s_axis_tready),
    .cmd       (cmd),
    .cfg       (cfg),
    .res_ready (res_ready),
    .status    (status)
  );

  // Output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (status.res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.res_valid && res_ready) m_axis_tdata <= {7'd0, status.res_bit};
  end

  // Engine keeps a read result until the output register takes it
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    status.res_valid && !res_ready |=> status.res_valid)
    else $error("read result dropped while output register full");

  // A clear starts the sweep and blocks input
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CLEAR) |=> !s_axis_tready)
    else $error("clear accepted without clearing pass");

  // Leaving reset always begins with the clearing pass
  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_axis_tready)
    else $error("input ready before mask cleared after reset");

endmodule

`default_nettype wire
